>>> rtl/mono_framebuffer_pixel_packer_macros.svh
// assertion helpers shared by the packer
`ifndef MONO_FRAMEBUFFER_PIXEL_PACKER_MACROS_SVH
`define MONO_FRAMEBUFFER_PIXEL_PACKER_MACROS_SVH

// implication checked at the same edge
`define MFP_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequence checked at a later edge than the antecedent
`define MFP_ASSERT_DLY2(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

>>> rtl/mfp_pkg.sv
package mfp_pkg;

  localparam int ADDR_CALC_W = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 10;
  localparam int DIM_W       = 10;

  localparam logic [CFG_IDX_W-1:0] REG_LANDSCAPE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd2;

  localparam logic             LANDSCAPE_RESET = 1'b1;
  localparam logic [DIM_W-1:0] WIDTH_RESET     = 10'd400;
  localparam logic [DIM_W-1:0] HEIGHT_RESET    = 10'd300;

  localparam logic [15:0] BLACK_LIMIT = 16'h7fff;
  localparam logic [7:0]  WHITE_BYTE  = 8'hff;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = 2;
  localparam int OUTQ_CNT_W = 3;

  typedef struct packed {
    logic                   op;
    logic                   ok;
    logic [ADDR_CALC_W-1:0] addr;
    logic [7:0]             mask;
    logic                   set;
  } mfp_req_t;

  typedef struct packed {
    logic clearing;
    logic c_read;
  } mfp_stat_t;

endpackage

>>> rtl/mfp_addr.sv
module mfp_addr
  import mfp_pkg::*;
#(
  parameter int FRAME_BYTES = 16384,
  parameter int MAX_DIM     = 512
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_fire,
  input  logic             landscape_mode,
  input  logic [DIM_W-1:0] frame_width,
  input  logic [DIM_W-1:0] frame_height,
  input  logic             operation,
  input  logic [8:0]       pixel_x,
  input  logic [8:0]       pixel_y,
  input  logic [15:0]      pixel_color,
  input  logic [13:0]      byte_index,
  output logic             b_valid,
  output mfp_req_t         b_req
);

  localparam logic [DIM_W:0]         DIM_LIMIT  = (DIM_W + 1)'(MAX_DIM);
  localparam logic [ADDR_CALC_W-1:0] BYTE_LIMIT = ADDR_CALC_W'(FRAME_BYTES);

  logic [DIM_W:0]         w_ext;
  logic [DIM_W:0]         h_ext;
  logic [DIM_W-1:0]       w_lim;
  logic [DIM_W-1:0]       h_lim;
  logic [DIM_W-1:0]       v;
  logic                   in_frame;
  logic [ADDR_CALC_W-1:0] land_addr;
  logic [ADDR_CALC_W-1:0] port_addr;
  logic [ADDR_CALC_W-1:0] pix_addr;
  logic [ADDR_CALC_W-1:0] rd_addr;
  logic [2:0]             pos;
  mfp_req_t               req;

  always_comb begin
    w_ext = ({1'b0, frame_width} > DIM_LIMIT) ? DIM_LIMIT : {1'b0, frame_width};
    h_ext = ({1'b0, frame_height} > DIM_LIMIT) ? DIM_LIMIT : {1'b0, frame_height};
    w_lim = w_ext[DIM_W-1:0];
    h_lim = h_ext[DIM_W-1:0];
    in_frame = ({1'b0, pixel_x} < w_lim) && ({1'b0, pixel_y} < h_lim);
    // flipped row, only meaningful when the pixel lies inside the frame
    v = h_lim - 10'd1 - {1'b0, pixel_y};
    land_addr = ADDR_CALC_W'(pixel_x[8:1]) * ADDR_CALC_W'(h_lim[9:2])
              + ADDR_CALC_W'(v[9:2]);
    port_addr = ADDR_CALC_W'(pixel_y[8:1]) * ADDR_CALC_W'(w_lim[9:2])
              + ADDR_CALC_W'(pixel_x[8:2]);
    pix_addr = landscape_mode ? land_addr : port_addr;
    pos = landscape_mode ? {v[1:0], pixel_x[0]} : {pixel_x[1:0], pixel_y[0]};
    rd_addr = ADDR_CALC_W'(byte_index);

    req.op   = operation;
    req.set  = (pixel_color >= BLACK_LIMIT);
    req.mask = 8'h80 >> pos;
    if (operation == OP_READ) begin
      req.addr = rd_addr;
      req.ok   = (rd_addr < BYTE_LIMIT);
    end else begin
      req.addr = pix_addr;
      req.ok   = in_frame && (pix_addr < BYTE_LIMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      b_req <= req;
    end
  end

endmodule

>>> rtl/mfp_store.sv
module mfp_store
  import mfp_pkg::*;
#(
  parameter int FRAME_BYTES = 16384
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       b_valid,
  input  mfp_req_t   b_req,
  output mfp_stat_t  stat,
  output logic       res_valid,
  output logic [7:0] res_data
);

  localparam int ADDR_W = $clog2(FRAME_BYTES);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(FRAME_BYTES - 1);

  logic [7:0]        mem [FRAME_BYTES];
  logic [7:0]        rdata;
  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;
  logic              c_valid;
  mfp_req_t          c_req;
  logic              fw_valid;
  logic [ADDR_W-1:0] fw_addr;
  logic [7:0]        fw_data;
  logic [ADDR_W-1:0] c_addr;
  logic [7:0]        cur;
  logic [7:0]        merged;
  logic              c_write;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]        wdata;

  assign c_addr = c_req.addr[ADDR_W-1:0];

  always_comb begin
    // the previous cycle's write is not yet visible in the read data
    cur = (fw_valid && fw_addr == c_addr) ? fw_data : rdata;
    merged = c_req.set ? (cur | c_req.mask) : (cur & ~c_req.mask);
    c_write = c_valid && (c_req.op == OP_WRITE) && c_req.ok;
    we    = clearing || c_write;
    waddr = clearing ? clr_addr : c_addr;
    wdata = clearing ? WHITE_BYTE : merged;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (b_valid && b_req.ok) begin
      rdata <= mem[b_req.addr[ADDR_W-1:0]];
    end
  end

  // white-out sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid  <= 1'b0;
      fw_valid <= 1'b0;
    end else begin
      c_valid  <= b_valid;
      fw_valid <= c_write;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid) begin
      c_req <= b_req;
    end
    fw_addr <= c_addr;
    fw_data <= merged;
  end

  assign res_valid = c_valid && (c_req.op == OP_READ);
  assign res_data  = c_req.ok ? cur : 8'h00;

  assign stat.clearing = clearing;
  assign stat.c_read   = res_valid;

endmodule

>>> rtl/mfp_outq.sv
module mfp_outq
  import mfp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [7:0]            push_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            read_byte,
  output logic [OUTQ_CNT_W-1:0] count
);

  logic [7:0]            q [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] wr_ptr;
  logic [OUTQ_PTR_W-1:0] rd_ptr;
  logic                  pop;

  assign out_valid = (count != '0);
  assign read_byte = q[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_data;
    end
  end

endmodule

>>> rtl/mono_framebuffer_pixel_packer.sv
// one-bit framebuffer packer for a reflective panel
// request channel: in_valid/in_ready with operation, pixel_x, pixel_y,
//   pixel_color and byte_index; a pixel write gives no response, a byte
//   read gives one read_byte on the out_valid/out_ready channel
// configuration: cfg_write with cfg_index and cfg_data, taken at once;
//   index 0 landscape_mode, 1 frame_width, 2 frame_height
// throughput is one request per cycle while in_ready is high, reads and
//   writes mixed, also when consecutive pixels land in the same byte (the
//   last write is forwarded into the read-modify-write stage)
// a read response passes the address-arithmetic register and then the
//   synchronous store read before it enters the response queue
// a four-entry response queue takes read data while the receiver stalls;
//   in_ready drops once in-flight reads would fill it, so nothing is lost
// after reset the store is swept to white, one byte a cycle, over all
//   FRAME_BYTES addresses; in_ready stays low during the sweep while
//   configuration writes are still taken
module mono_framebuffer_pixel_packer
  import mfp_pkg::*;
#(
  parameter int FRAME_BYTES = 16384,
  parameter int MAX_DIM     = 512
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  operation,
  input  logic [8:0]            pixel_x,
  input  logic [8:0]            pixel_y,
  input  logic [15:0]           pixel_color,
  input  logic [13:0]           byte_index,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            read_byte
);

  `include "mono_framebuffer_pixel_packer_macros.svh"

  logic                  landscape_mode;
  logic [DIM_W-1:0]      frame_width;
  logic [DIM_W-1:0]      frame_height;
  logic                  in_fire;
  logic                  b_valid;
  mfp_req_t              b_req;
  mfp_stat_t             stat;
  logic                  res_valid;
  logic [7:0]            res_data;
  logic [OUTQ_CNT_W-1:0] q_count;
  logic [OUTQ_CNT_W:0]   committed;

  always_ff @(posedge clk) begin
    if (rst) begin
      landscape_mode <= LANDSCAPE_RESET;
      frame_width    <= WIDTH_RESET;
      frame_height   <= HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LANDSCAPE: landscape_mode <= cfg_data[0];
        REG_WIDTH:     frame_width    <= cfg_data[DIM_W-1:0];
        REG_HEIGHT:    frame_height   <= cfg_data[DIM_W-1:0];
        default:       landscape_mode <= landscape_mode;
      endcase
    end
  end

  // queue slots already filled or promised to reads in flight
  assign committed = {1'b0, q_count}
                   + (OUTQ_CNT_W + 1)'(b_valid && (b_req.op == OP_READ))
                   + (OUTQ_CNT_W + 1)'(stat.c_read);
  assign in_ready  = !stat.clearing && (committed < (OUTQ_CNT_W + 1)'(OUTQ_DEPTH));
  assign in_fire   = in_valid && in_ready;

  mfp_addr #(
    .FRAME_BYTES (FRAME_BYTES),
    .MAX_DIM     (MAX_DIM)
  ) u_addr (
    .clk            (clk),
    .rst            (rst),
    .in_fire        (in_fire),
    .landscape_mode (landscape_mode),
    .frame_width    (frame_width),
    .frame_height   (frame_height),
    .operation      (operation),
    .pixel_x        (pixel_x),
    .pixel_y        (pixel_y),
    .pixel_color    (pixel_color),
    .byte_index     (byte_index),
    .b_valid        (b_valid),
    .b_req          (b_req)
  );

  mfp_store #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .b_valid   (b_valid),
    .b_req     (b_req),
    .stat      (stat),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  mfp_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .read_byte (read_byte),
    .count     (q_count)
  );

  `MFP_ASSERT_IMP(a_queue_no_overflow, q_count == OUTQ_CNT_W'(OUTQ_DEPTH), !res_valid, "response queue overflow")
  `MFP_ASSERT_DLY2(a_read_responds, in_fire && operation == OP_READ, res_valid, "read request lost")
  `MFP_ASSERT_DLY2(a_write_silent, in_fire && operation == OP_WRITE, !res_valid, "pixel write produced a response")
  `MFP_ASSERT_IMP(a_idle_while_clearing, stat.clearing, !b_valid && !res_valid, "request in flight during sweep")

endmodule

>>> sim/mono_framebuffer_pixel_packer_test.sv
module mono_framebuffer_pixel_packer_test;
  import mfp_pkg::*;

  localparam int FRAME_BYTES    = 16384;
  localparam int MAX_DIM        = 512;
  localparam int WATCHDOG_LIMIT = 100000;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct {
    logic        op;
    logic [8:0]  x;
    logic [8:0]  y;
    logic [15:0] color;
    logic [13:0] index;
  } pixel_req_t;

  typedef struct {
    logic [13:0] index;
    logic [7:0]  value;
  } byte_check_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_LANDSCAPE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  operation = OP_WRITE;
  logic [8:0]            pixel_x = '0;
  logic [8:0]            pixel_y = '0;
  logic [15:0]           pixel_color = '0;
  logic [13:0]           byte_index = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [7:0]            read_byte;

  // shadow of the framebuffer and its registers
  logic [7:0]      frame_model [FRAME_BYTES];
  logic            model_landscape = LANDSCAPE_RESET;
  logic [DIM_W-1:0] model_width    = WIDTH_RESET;
  logic [DIM_W-1:0] model_height   = HEIGHT_RESET;

  pixel_req_t  pixel_req_q [$];
  byte_check_t read_byte_q [$];
  pixel_req_t  cur_req;
  byte_check_t seen_check;
  int          requests_open = 0;
  int          mismatch_count = 0;
  int          send_gap = 0;
  int          drain_gap = 0;
  int          stuck_cycles = 0;
  bit          jitter_on = 1'b1;
  logic [13:0] recent_index = '0;

  mono_framebuffer_pixel_packer #(
    .FRAME_BYTES (FRAME_BYTES),
    .MAX_DIM     (MAX_DIM)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .byte_index  (byte_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .read_byte   (read_byte)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned frame_w();
    return (int'(model_width) > MAX_DIM) ? MAX_DIM : int'(model_width);
  endfunction

  function automatic int unsigned frame_h();
    return (int'(model_height) > MAX_DIM) ? MAX_DIM : int'(model_height);
  endfunction

  // byte address and in-block position of a pixel under the current packing
  function automatic int unsigned pixel_addr(int unsigned x, int unsigned y,
                                             output int unsigned pos);
    int unsigned w;
    int unsigned h;
    int unsigned v;
    w = frame_w();
    h = frame_h();
    if (model_landscape) begin
      v = h - 1 - y;
      pos = ((v % 4) << 1) | (x % 2);
      return (x / 2) * (h / 4) + v / 4;
    end
    pos = ((x % 4) << 1) | (y % 2);
    return (y / 2) * (w / 4) + x / 4;
  endfunction

  function automatic void apply_to_frame(pixel_req_t r);
    int unsigned addr;
    int unsigned pos;
    byte_check_t chk;
    if (r.op == OP_READ) begin
      chk.index = r.index;
      chk.value = (r.index < FRAME_BYTES) ? frame_model[r.index] : 8'h00;
      read_byte_q.push_back(chk);
    end else if (r.x < frame_w() && r.y < frame_h()) begin
      addr = pixel_addr(int'(r.x), int'(r.y), pos);
      if (addr < FRAME_BYTES) begin
        if (r.color < BLACK_LIMIT)
          frame_model[addr[13:0]] &= ~(8'h80 >> pos);
        else
          frame_model[addr[13:0]] |= (8'h80 >> pos);
      end
    end
    requests_open--;
  endfunction

  function automatic void push_write(logic [8:0] x, logic [8:0] y, logic [15:0] color);
    pixel_req_t r;
    r.op    = OP_WRITE;
    r.x     = x;
    r.y     = y;
    r.color = color;
    r.index = 14'($urandom_range(0, FRAME_BYTES - 1));
    pixel_req_q.push_back(r);
    requests_open++;
  endfunction

  function automatic void push_read(logic [13:0] idx);
    pixel_req_t r;
    r.op    = OP_READ;
    r.x     = 9'($urandom_range(0, 511));
    r.y     = 9'($urandom_range(0, 511));
    r.color = 16'($urandom_range(0, 65535));
    r.index = idx;
    pixel_req_q.push_back(r);
    requests_open++;
  endfunction

  function automatic logic [15:0] pick_color();
    case ($urandom_range(0, 7))
      0: return BLACK_LIMIT - 16'd1;
      1: return BLACK_LIMIT;
      2: return BLACK_LIMIT + 16'd1;
      3: return 16'h0000;
      4: return 16'hffff;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // mostly in-frame writes, often clustered into one byte, with reads of
  // recently touched bytes; the rest lands anywhere
  task automatic queue_random(int count);
    int i;
    int unsigned w;
    int unsigned h;
    int unsigned pick;
    int unsigned nx;
    int unsigned ny;
    int unsigned last_x;
    int unsigned last_y;
    int unsigned addr;
    int unsigned pos;
    w = frame_w();
    h = frame_h();
    last_x = 0;
    last_y = 0;
    for (i = 0; i < count; i++) begin
      pick = $urandom_range(0, 9);
      if (pick <= 4 && w > 0 && h > 0) begin
        nx = last_x ^ $urandom_range(0, 3);
        ny = last_y ^ $urandom_range(0, 3);
        if ($urandom_range(0, 2) != 0 || nx >= w || ny >= h) begin
          nx = $urandom_range(0, w - 1);
          ny = $urandom_range(0, h - 1);
        end
        last_x = nx;
        last_y = ny;
        addr = pixel_addr(nx, ny, pos);
        recent_index = addr[13:0];
        push_write(9'(nx), 9'(ny), pick_color());
      end else if (pick == 5) begin
        push_write(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)), pick_color());
      end else if (pick <= 8) begin
        push_read(recent_index);
      end else begin
        push_read(14'($urandom_range(0, FRAME_BYTES - 1)));
      end
    end
  endtask

  // wait until every request is taken and every read has come back
  task automatic settle();
    do @(posedge clk);
    while (requests_open != 0 || read_byte_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_frame(logic mode, logic [9:0] w, logic [9:0] h);
    logic [8:0] junk;
    junk = 9'($urandom_range(0, 511));
    cfg_write <= 1'b1;
    cfg_index <= REG_LANDSCAPE;
    cfg_data  <= {junk, mode};
    model_landscape = mode;
    @(posedge clk);
    cfg_index <= REG_WIDTH;
    cfg_data  <= w;
    model_width = w;
    @(posedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_data  <= h;
    model_height = h;
    @(posedge clk);
    // spare index, must leave everything alone
    cfg_index <= REG_SPARE;
    cfg_data  <= 10'($urandom_range(0, 1023));
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        apply_to_frame(cur_req);
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pixel_req_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (jitter_on && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 2);
          in_valid <= 1'b0;
        end else begin
          cur_req = pixel_req_q.pop_front();
          in_valid    <= 1'b1;
          operation   <= cur_req.op;
          pixel_x     <= cur_req.x;
          pixel_y     <= cur_req.y;
          pixel_color <= cur_req.color;
          byte_index  <= cur_req.index;
        end
      end
    end
  end

  // read data monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (read_byte_q.size() == 0) begin
          report_mismatch($sformatf("read_byte %02h with no read outstanding", read_byte));
        end else begin
          seen_check = read_byte_q.pop_front();
          if (read_byte !== seen_check.value)
            report_mismatch($sformatf("byte %0d: read_byte %02h, want %02h",
                                      seen_check.index, read_byte, seen_check.value));
        end
      end
      if (drain_gap > 0) begin
        drain_gap--;
        out_ready <= 1'b0;
      end else if (jitter_on && $urandom_range(0, 7) == 0) begin
        drain_gap = $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // covers the white sweep after reset with plenty of margin
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: nothing accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int phase;
    int unsigned pos;
    foreach (frame_model[i]) frame_model[i] = WHITE_BYTE;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset packing: landscape, 400 by 300
    push_read(14'd0);
    push_read(14'(FRAME_BYTES - 1));
    push_write(9'd0, 9'd0, 16'h0000);
    push_read(14'(pixel_addr(0, 0, pos)));
    push_write(9'd399, 9'd299, BLACK_LIMIT - 16'd1);
    push_write(9'd398, 9'd299, BLACK_LIMIT);
    push_read(14'(pixel_addr(399, 299, pos)));
    // outside the frame, dropped
    push_write(9'd400, 9'd10, 16'h0000);
    push_write(9'd10, 9'd300, 16'h0000);
    push_write(9'd511, 9'd511, 16'h0000);
    push_read(14'(pixel_addr(400, 10, pos)));
    // every position of one byte back to back
    for (int i = 0; i < 8; i++)
      push_write(9'(2 + i % 2), 9'(4 + i / 2), (i % 3 == 0) ? 16'hffff : 16'h0000);
    push_read(14'(pixel_addr(2, 4, pos)));
    push_write(9'd3, 9'd7, 16'h8000);
    push_read(14'(pixel_addr(3, 7, pos)));
    settle();

    for (phase = 0; phase < 9; phase++) begin
      case (phase)
        0: program_frame(1'b0, 10'd4, 10'd4);
        1: program_frame(1'b1, 10'd512, 10'd512);
        2: program_frame(1'b0, 10'd1023, 10'd1023);
        3: program_frame(1'b1, 10'd4, 10'd4);
        4: program_frame(1'b1, 10'd0, 10'd1023);
        5: program_frame(1'b0, 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
        6: program_frame(1'b1, 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
        7: program_frame(1'b0, 10'd512, 10'd512);
        default: program_frame(1'b1, 10'd400, 10'd300);
      endcase
      jitter_on = (phase % 3 != 2) && (phase < 8);
      queue_random((phase == 4) ? 60 : 170);
      settle();
    end

    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/mfp_pkg.sv
rtl/mfp_addr.sv
rtl/mfp_store.sv
rtl/mfp_outq.sv
rtl/mono_framebuffer_pixel_packer.sv
sim/mono_framebuffer_pixel_packer_test.sv
